FILE: src/lobm_pkg.sv
// Shared types and constants for the limit order book matcher.
// No dependencies.
`default_nettype none

package lobm_pkg;

    localparam logic RESULT_TRADE   = 1'b0;
    localparam logic RESULT_SUMMARY = 1'b1;

    typedef struct packed {
        logic        is_bid;
        logic [15:0] order_item;
        logic [30:0] limit_price;
        logic [30:0] order_volume;
        logic [31:0] trader_id;
    } order_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] buyer_id;
        logic [31:0] seller_id;
        logic [15:0] trade_item;
        logic [30:0] trade_quantity;
        logic [61:0] trade_amount;
        logic [30:0] leftover_volume;
        logic        book_full;
        logic        last;
    } result_t;

    // one resting order as held in the slot RAM
    typedef struct packed {
        logic [15:0] item;
        logic [30:0] price;
        logic [30:0] volume;
        logic [31:0] owner;
        logic [31:0] stamp;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // best-candidate state carried between scan steps
    typedef struct packed {
        logic        found;
        logic [30:0] price;
        logic [31:0] age;
    } best_t;

endpackage

`default_nettype wire

FILE: src/lobm_stream_if.sv
// Valid/ready stream interface with a typed payload.
// No dependencies.
`default_nettype none

interface lobm_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/lobm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

FILE: src/lobm_cmp.sv
// Shared compare unit: crossing test and price-time priority against the best so far.
// Depends on lobm_pkg.
`default_nettype none

module lobm_cmp
    import lobm_pkg::*;
(
    input  wire logic        live,
    input  wire slot_t       entry,
    input  wire logic        is_bid,
    input  wire logic [15:0] item,
    input  wire logic [30:0] limit,
    input  wire logic [31:0] counter,
    input  wire best_t       best,
    output      logic        better,
    output      logic [31:0] age
);
    logic crosses;

    always_comb
    begin
        age     = counter - entry.stamp;
        crosses = is_bid ? (entry.price <= limit) : (entry.price >= limit);
        better  = 1'b0;
        if (live && entry.item == item && crosses)
        begin
            priority if (!best.found)
                better = 1'b1;
            else if (entry.price != best.price)
                better = is_bid ? (entry.price < best.price) : (entry.price > best.price);
            else
                better = age > best.age; // ties keep the lower slot
        end
    end
endmodule

`default_nettype wire

FILE: src/limit_order_book_matcher_top.sv
// Top level of the limit order book matcher: sequencer, live bits, output register.
// Depends on lobm_pkg, lobm_stream_if, lobm_ram, lobm_cmp.
//
// Usage:
//   orders  : sink of order_t transactions (side, item, limit, volume, trader).
//   results : source of result_t transactions; zero or more trade records
//             followed by one summary with last set.
//   One order is worked on at a time; orders.ready is high only when idle.
//   Each fill scans the opposite side's SLOTS_PER_SIDE slots through the
//   slot RAM read port, one slot per cycle into the shared compare unit:
//   a setup step, the scan, then min, multiply and trade emit. Resting the
//   leftover scans the own side's live bits, then the summary is emitted.
//   Reset clears all live bits and the arrival counter at once; no clearing
//   pass is needed, the RAM contents are only read behind a live bit.
//   A stalled receiver holds the output register; the sequencer waits in
//   its emit state until the register is free.
`default_nettype none

module limit_order_book_matcher_top
    import lobm_pkg::*;
#(
    parameter int SLOTS_PER_SIDE = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lobm_stream_if.sink   orders,
    lobm_stream_if.source results
);
    localparam int NSLOTS = 2 * SLOTS_PER_SIDE;
    localparam int AW     = $clog2(NSLOTS);
    localparam int CW     = $clog2(SLOTS_PER_SIDE + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(SLOTS_PER_SIDE);
    localparam logic [AW-1:0] ASK_BASE = AW'(SLOTS_PER_SIDE);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOOP  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_PICK  = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_TRADE = 3'd5;
    localparam logic [2:0] ST_REST  = 3'd6;
    localparam logic [2:0] ST_SUM   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [NSLOTS-1:0] live_reg, live_next;
    logic [31:0]       counter_reg, counter_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     fills_reg, fills_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     cmp_addr_reg, cmp_addr_next;
    order_t            ord_reg, ord_next;
    best_t             best_reg, best_next;
    logic [AW-1:0]     best_addr_reg, best_addr_next;
    slot_t             best_slot_reg, best_slot_next;
    logic [30:0]       qty_reg, qty_next;
    logic [61:0]       amount_reg, amount_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    // slot RAM ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    slot_t         ram_wdata, ram_rdata;

    logic          cmp_better;
    logic [31:0]   cmp_age;
    logic          out_free;
    logic [AW-1:0] opp_base, own_base, own_addr;

    lobm_ram #(.WIDTH(SLOT_W), .DEPTH(NSLOTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lobm_cmp u_cmp (
        .live    (live_reg[cmp_addr_reg]),
        .entry   (ram_rdata),
        .is_bid  (ord_reg.is_bid),
        .item    (ord_reg.order_item),
        .limit   (ord_reg.limit_price),
        .counter (counter_reg),
        .best    (best_reg),
        .better  (cmp_better),
        .age     (cmp_age)
    );

    assign orders.ready  = (state_reg == ST_IDLE);
    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;
    assign out_free      = !out_valid_reg || results.ready;

    // bids live in the lower half, asks in the upper half
    assign opp_base = ord_reg.is_bid ? ASK_BASE : '0;
    assign own_base = ord_reg.is_bid ? '0 : ASK_BASE;
    assign own_addr = own_base + AW'(idx_reg);

    always_comb
    begin
        state_next     = state_reg;
        live_next      = live_reg;
        counter_next   = counter_reg;
        idx_next       = idx_reg;
        fills_next     = fills_reg;
        pend_next      = 1'b0;
        cmp_addr_next  = cmp_addr_reg;
        ord_next       = ord_reg;
        best_next      = best_reg;
        best_addr_next = best_addr_reg;
        best_slot_next = best_slot_reg;
        qty_next       = qty_reg;
        amount_next    = amount_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = best_addr_reg;
        ram_wdata      = best_slot_reg;
        ram_raddr      = opp_base + AW'(idx_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (orders.valid)
                begin
                    ord_next   = orders.data;
                    fills_next = '0;
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                idx_next = '0;
                if (ord_reg.order_volume != '0 && fills_reg != LAST_IDX)
                begin
                    best_next.found = 1'b0;
                    state_next      = ST_SCAN;
                end
                else
                begin
                    state_next = ST_REST;
                end
            end
            ST_SCAN:
            begin
                // read issued this cycle, compared on the next
                if (idx_reg != LAST_IDX)
                begin
                    pend_next     = 1'b1;
                    cmp_addr_next = ram_raddr;
                    idx_next      = idx_reg + 1'b1;
                end
                if (pend_reg && cmp_better)
                begin
                    best_next.found = 1'b1;
                    best_next.price = ram_rdata.price;
                    best_next.age   = cmp_age;
                    best_addr_next  = cmp_addr_reg;
                    best_slot_next  = ram_rdata;
                end
                if (idx_reg == LAST_IDX && !pend_reg)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                idx_next = '0;
                if (!best_reg.found)
                begin
                    state_next = ST_REST;
                end
                else
                begin
                    qty_next = (ord_reg.order_volume < best_slot_reg.volume)
                             ? ord_reg.order_volume : best_slot_reg.volume;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                amount_next = 62'(qty_reg) * 62'(best_slot_reg.price);
                state_next  = ST_TRADE;
            end
            ST_TRADE:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next                = '0;
                    out_next.result_kind    = RESULT_TRADE;
                    out_next.buyer_id       = ord_reg.is_bid ? ord_reg.trader_id
                                                             : best_slot_reg.owner;
                    out_next.seller_id      = ord_reg.is_bid ? best_slot_reg.owner
                                                             : ord_reg.trader_id;
                    out_next.trade_item     = ord_reg.order_item;
                    out_next.trade_quantity = qty_reg;
                    out_next.trade_amount   = amount_reg;
                    ram_we           = 1'b1;
                    ram_wdata.volume = best_slot_reg.volume - qty_reg;
                    if (best_slot_reg.volume == qty_reg)
                    begin
                        live_next[best_addr_reg] = 1'b0;
                    end
                    ord_next.order_volume = ord_reg.order_volume - qty_reg;
                    fills_next            = fills_reg + 1'b1;
                    state_next            = ST_LOOP;
                end
            end
            ST_REST:
            begin
                priority if (ord_reg.order_volume == '0)
                begin
                    best_next.found = 1'b0;
                    state_next      = ST_SUM;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    best_next.found = 1'b1; // reused as the full flag
                    state_next      = ST_SUM;
                end
                else if (!live_reg[own_addr])
                begin
                    ram_we             = 1'b1;
                    ram_waddr          = own_addr;
                    ram_wdata.item     = ord_reg.order_item;
                    ram_wdata.price    = ord_reg.limit_price;
                    ram_wdata.volume   = ord_reg.order_volume;
                    ram_wdata.owner    = ord_reg.trader_id;
                    ram_wdata.stamp    = counter_reg;
                    live_next[own_addr] = 1'b1;
                    counter_next       = counter_reg + 1'b1;
                    best_next.found    = 1'b0;
                    state_next         = ST_SUM;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_next                 = '0;
                    out_next.result_kind     = RESULT_SUMMARY;
                    out_next.leftover_volume = ord_reg.order_volume;
                    out_next.book_full       = best_reg.found;
                    out_next.last            = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            live_reg      <= '0;
            counter_reg   <= '0;
            idx_reg       <= '0;
            fills_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            counter_reg   <= counter_next;
            idx_reg       <= idx_next;
            fills_reg     <= fills_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_addr_reg  <= cmp_addr_next;
        ord_reg       <= ord_next;
        best_reg      <= best_next;
        best_addr_reg <= best_addr_next;
        best_slot_reg <= best_slot_next;
        qty_reg       <= qty_next;
        amount_reg    <= amount_next;
        out_reg       <= out_next;
    end

`ifndef NO_ASSERTIONS
    // never more fills than one side holds
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fills_reg <= LAST_IDX)
        else $error("fill count beyond side size");

    // an accepted order leaves idle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        orders.valid && orders.ready |=> state_reg != ST_IDLE)
        else $error("order accepted but sequencer idle");

    // a trade emit loads a non-last trade record
    a_trade_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TRADE && out_free |=>
            out_valid_reg && out_reg.result_kind == RESULT_TRADE && !out_reg.last)
        else $error("trade emit did not load a trade record");
`endif

endmodule

`default_nettype wire

FILE: bench/limit_order_book_matcher_checker.sv
// Checker for the limit order book matcher: watches both channels, predicts
// results from accepted orders and compares them. Depends on lobm_pkg.
module limit_order_book_matcher_checker
    import lobm_pkg::*;
#(
    parameter int SLOTS_PER_SIDE = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic ord_valid,
    input  wire logic ord_ready,
    input  order_t    ord_data,
    input  wire logic res_valid,
    input  wire logic res_ready,
    input  result_t   res_data,
    output int        error_count,
    output int        pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS = 2 * SLOTS_PER_SIDE;

    logic        book_live  [NSLOTS];
    logic [15:0] book_item  [NSLOTS];
    logic [30:0] book_price [NSLOTS];
    logic [30:0] book_vol   [NSLOTS];
    logic [31:0] book_owner [NSLOTS];
    logic [31:0] book_stamp [NSLOTS];
    logic [31:0] arrivals;

    result_t expected_fills[$];

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic int best_resting(input order_t o);
        int base;
        int best;
        logic [30:0] bp;
        logic [31:0] ba;
        logic [31:0] age;
        logic better;
        base = o.is_bid ? SLOTS_PER_SIDE : 0;
        best = -1;
        bp = '0;
        ba = '0;
        for (int i = base; i < base + SLOTS_PER_SIDE; i++) begin
            if (!book_live[i] || book_item[i] != o.order_item)
                continue;
            if (o.is_bid ? (book_price[i] > o.limit_price) : (book_price[i] < o.limit_price))
                continue;
            age = arrivals - book_stamp[i];
            if (best < 0)
                better = 1'b1;
            else if (book_price[i] != bp)
                better = o.is_bid ? (book_price[i] < bp) : (book_price[i] > bp);
            else
                better = age > ba;
            if (better)
            begin
                best = i;
                bp = book_price[i];
                ba = age;
            end
        end
        return best;
    endfunction

    task automatic match_order(input order_t o);
        logic [30:0] vol;
        int fills;
        int s;
        int free_slot;
        result_t r;
        vol = o.order_volume;
        fills = 0;
        while (vol != 0 && fills < SLOTS_PER_SIDE) begin
            s = best_resting(o);
            if (s < 0)
                break;
            r = '0;
            r.result_kind    = RESULT_TRADE;
            r.buyer_id       = o.is_bid ? o.trader_id : book_owner[s];
            r.seller_id      = o.is_bid ? book_owner[s] : o.trader_id;
            r.trade_item     = o.order_item;
            r.trade_quantity = (vol < book_vol[s]) ? vol : book_vol[s];
            r.trade_amount   = 62'(r.trade_quantity) * 62'(book_price[s]);
            expected_fills.push_back(r);
            fills++;
            vol -= r.trade_quantity;
            book_vol[s] -= r.trade_quantity;
            if (book_vol[s] == 0)
                book_live[s] = 1'b0;
        end
        r = '0;
        r.result_kind = RESULT_SUMMARY;
        r.last = 1'b1;
        r.leftover_volume = vol;
        if (vol != 0) begin
            free_slot = -1;
            for (int i = (o.is_bid ? 0 : SLOTS_PER_SIDE);
                 i < (o.is_bid ? SLOTS_PER_SIDE : NSLOTS); i++)
                if (free_slot < 0 && !book_live[i])
                    free_slot = i;
            if (free_slot < 0)
                r.book_full = 1'b1;
            else
            begin
                book_live[free_slot]  = 1'b1;
                book_item[free_slot]  = o.order_item;
                book_price[free_slot] = o.limit_price;
                book_vol[free_slot]   = vol;
                book_owner[free_slot] = o.trader_id;
                book_stamp[free_slot] = arrivals;
                arrivals++;
            end
        end
        expected_fills.push_back(r);
    endtask

    task automatic compare_result(input result_t got);
        result_t w;
        if (expected_fills.size() == 0) begin
            report_mismatch("result with nothing expected");
            return;
        end
        w = expected_fills.pop_front();
        if (got.result_kind !== w.result_kind) report_mismatch("result_kind");
        if (got.buyer_id !== w.buyer_id) report_mismatch("buyer_id");
        if (got.seller_id !== w.seller_id) report_mismatch("seller_id");
        if (got.trade_item !== w.trade_item) report_mismatch("trade_item");
        if (got.trade_quantity !== w.trade_quantity) report_mismatch("trade_quantity");
        if (got.trade_amount !== w.trade_amount) report_mismatch("trade_amount");
        if (got.leftover_volume !== w.leftover_volume) report_mismatch("leftover_volume");
        if (got.book_full !== w.book_full) report_mismatch("book_full");
        if (got.last !== w.last) report_mismatch("last");
    endtask

    initial begin
        error_count = 0;
        pending_count = 0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            book_live[i] = 1'b0;
            book_item[i] = '0;
            book_price[i] = '0;
            book_vol[i] = '0;
            book_owner[i] = '0;
            book_stamp[i] = '0;
        end
        arrivals = '0;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (res_valid && res_ready)
                compare_result(res_data);
            if (ord_valid && ord_ready)
                match_order(ord_data);
            pending_count = expected_fills.size();
        end
    end

endmodule

FILE: bench/limit_order_book_matcher_top_test.sv
// Testbench top for the limit order book matcher: clock, reset, order stimulus, result
// backpressure, watchdog and verdict. Depends on lobm_pkg, lobm_stream_if, top, checker.
module limit_order_book_matcher_top_test;
    import lobm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 32;
    // bound for a single order, covering its fills, a failed scan and the resting scan
    localparam int ORDER_CYCLES = SLOTS * (SLOTS + 6) + 2 * SLOTS + 7;
    localparam int WATCHDOG_LIMIT = 20 * ORDER_CYCLES + 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lobm_stream_if #(.T(order_t))  orders ();
    lobm_stream_if #(.T(result_t)) results ();

    int errors;
    int pending;
    int send_idle_pct = 35;   // sender gap percentage for the current phase
    int recv_idle_pct = 67;   // receiver stall percentage
    logic long_hold = 1'b0;   // receiver holds off while set
    int quiet_cycles = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    limit_order_book_matcher_top #(.SLOTS_PER_SIDE(SLOTS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .orders(orders.sink),
        .results(results.source)
    );

    limit_order_book_matcher_checker #(.SLOTS_PER_SIDE(SLOTS)) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .ord_valid(orders.valid),
        .ord_ready(orders.ready),
        .ord_data(orders.data),
        .res_valid(results.valid),
        .res_ready(results.ready),
        .res_data(results.data),
        .error_count(errors),
        .pending_count(pending)
    );

    initial begin
        orders.valid = 1'b0;
        orders.data = '0;
        results.ready = 1'b0;
    end

    // Receiver: random stalls per phase, plus a long hold-off on request.
    always @(posedge clk) begin
        if (!rst_n || long_hold)
            results.ready <= 1'b0;
        else
            results.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: counts cycles with no transaction on either channel.
    always @(posedge clk) begin
        if ((orders.valid && orders.ready) || (results.valid && results.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("limit_order_book_matcher_top_test: errors");
            $finish;
        end
    end

    // Offer one order and hold it until the transaction completes.
    // The block is busy for many cycles after an accept, so the edge spent
    // after dropping valid costs no throughput.
    task automatic send_order(input order_t o);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        orders.valid <= 1'b1;
        orders.data <= o;
        @(posedge clk);
        while (!orders.ready)
            @(posedge clk);
        orders.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic place(input logic bid, input logic [15:0] item, input logic [30:0] price,
                         input logic [30:0] vol, input logic [31:0] trader);
        order_t o;
        o.is_bid = bid;
        o.order_item = item;
        o.limit_price = price;
        o.order_volume = vol;
        o.trader_id = trader;
        send_order(o);
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(posedge clk);
    endtask

    // Random order on a handful of items and a narrow price band so orders cross.
    // One in eight uses full-range fields to reach every bit.
    task automatic random_order();
        order_t o;
        o.is_bid = 1'($urandom_range(1));
        o.trader_id = $urandom;
        if ($urandom_range(7) == 0) begin
            o.order_item = 16'($urandom);
            o.limit_price = 31'($urandom);
            o.order_volume = 31'($urandom);
        end
        else
        begin
            o.order_item = 16'($urandom_range(3));
            o.limit_price = 31'd1000 + 31'($urandom_range(20));
            o.order_volume = ($urandom_range(9) == 0) ? 31'd0 : 31'($urandom_range(1, 50));
        end
        send_order(o);
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: price-time priority on item 7, two asks at the same price.
        place(1'b0, 16'd7, 31'd100, 31'd10, 32'hA);
        place(1'b0, 16'd7, 31'd100, 31'd10, 32'hB);   // same price, younger
        place(1'b0, 16'd7, 31'd90, 31'd5, 32'hC);     // better price
        place(1'b1, 16'd7, 31'd100, 31'd18, 32'hD);   // sweeps C, then A, then B partly
        place(1'b1, 16'd7, 31'd50, 31'd5, 32'hE);     // no cross, rests
        place(1'b0, 16'd7, 31'd40, 31'd30, 32'hF);    // takes bid E then rests
        place(1'b1, 16'd7, 31'd0, 31'd0, 32'h0);      // zero volume
        // extremes of every field
        place(1'b0, 16'hFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF);
        place(1'b1, 16'hFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 32'h0);  // max amount
        place(1'b1, 16'h0, 31'h0, 31'h1, 32'hFFFFFFFF);
        place(1'b0, 16'h0, 31'h0, 31'h1, 32'h12345678);

        // Fill the ask side of item 9, then overflow it; a large bid then
        // takes every resting item 9 ask in one order.
        for (int i = 0; i < SLOTS + 1; i++)
            place(1'b0, 16'd9, 31'(200 + (i % 3)), 31'd1, 32'(i));
        place(1'b1, 16'd9, 31'd500, 31'd100, 32'h77);
        wait_drained();

        // Pressure: receiver holds off long while the sender keeps offering.
        fork
            begin
                long_hold = 1'b1;
                repeat (600) @(posedge clk);
                long_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 6; i++)
                    random_order();
            end
        join
        wait_drained();

        for (int i = 0; i < 15; i++)
            random_order();
        send_idle_pct = 67;
        recv_idle_pct = 35;
        for (int i = 0; i < 15; i++)
            random_order();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 13; i++)
            random_order();

        wait_drained();
        repeat (ORDER_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("limit_order_book_matcher_top_test: clean");
        else
            $display("limit_order_book_matcher_top_test: errors");
        $finish;
    end

endmodule

FILE: sim.f
src/lobm_pkg.sv
src/lobm_stream_if.sv
src/lobm_ram.sv
src/lobm_cmp.sv
src/limit_order_book_matcher_top.sv
bench/limit_order_book_matcher_checker.sv
bench/limit_order_book_matcher_top_test.sv
